[rtl/pnz_pkg.sv]
// shared types, constants and gradient tables for the 2d gradient noise pipeline
package pnz_pkg;

   localparam int FB = 28;
   localparam logic [25:0] R289 = 26'd59445914;
   localparam logic [31:0] R82 = 32'd3352169596;
   localparam logic [30:0] NORM_C1 = 31'd481262605;
   localparam longint NORM_C2 = 229172669;
   localparam logic [29:0] SCALE_K = 30'd617401549;

   typedef logic [8:0] cell_type;
   typedef logic [27:0] frac_type;
   typedef logic signed [29:0] off_type;
   typedef logic signed [31:0] corner_type;
   typedef logic signed [29:0] fade_type;
   typedef logic [5:0] hmod_type;
   typedef logic signed [6:0] grad_type;
   typedef logic [30:0] norm_type;
   typedef norm_type norm_tbl_type [0:40];

   function automatic grad_type grad_x(input hmod_type m);
      logic signed [7:0] t;
      logic signed [7:0] g;
      t = $signed({1'b0, m, 1'b0}) - 8'sd41;
      if (m <= 6'd10) begin
         g = (t <<< 1) + 8'sd82;
      end else if (m >= 6'd31) begin
         g = (t <<< 1) - 8'sd82;
      end else begin
         g = t <<< 1;
      end
      return g[6:0];
   endfunction

   function automatic grad_type grad_y(input hmod_type m);
      logic signed [7:0] t;
      logic signed [7:0] a;
      logic signed [7:0] g;
      t = $signed({1'b0, m, 1'b0}) - 8'sd41;
      a = (t < 0) ? -t : t;
      g = (a <<< 1) - 8'sd41;
      return g[6:0];
   endfunction

   function automatic norm_tbl_type build_norm_tbl();
      norm_tbl_type tb;
      longint gx;
      longint gy;
      longint s;
      for (int i = 0; i < 41; i++) begin
         gx = longint'(grad_x(hmod_type'(i)));
         gy = longint'(grad_y(hmod_type'(i)));
         s = gx * gx + gy * gy;
         tb[i] = norm_type'(longint'(NORM_C1) - (NORM_C2 * s + 3362) / 6724);
      end
      return tb;
   endfunction

   localparam norm_tbl_type NORM_TBL = build_norm_tbl();

endpackage

[rtl/pnz_fade.sv]
// quintic fade curve 6t^5 - 15t^4 + 10t^3, six register stages
module pnz_fade (
   input  logic              clock,
   input  pnz_pkg::frac_type t_in,
   output pnz_pkg::fade_type fade_out
);
   import pnz_pkg::*;

   logic        [27:0] t_ff [2];
   logic signed [65:0] pa_ff;
   logic        [55:0] pt_ff;
   logic signed [32:0] b_ff [3];
   logic        [28:0] t2_ff;
   logic        [56:0] pt3_ff;
   logic        [28:0] t3_ff;
   logic signed [63:0] pf_ff;
   fade_type           fade_ff;

   logic signed [32:0] ta;
   logic signed [32:0] a_in;
   logic signed [65:0] pa_in;
   logic        [55:0] pt_in;
   logic signed [65:0] b_full;
   logic signed [32:0] b_in;
   logic        [55:0] t2_full;
   logic        [56:0] t3_full;
   logic signed [63:0] pf_in;
   logic signed [63:0] fade_full;

   always_comb begin
      ta = $signed({5'b0, t_in});
      a_in = ta * 33'sd6 - 33'sd4026531840;
      pa_in = a_in * ta;
      pt_in = 56'(t_in) * 56'(t_in);
      b_full = (pa_ff + 66'sd134217728) >>> FB;
      b_in = 33'(b_full) + 33'sd2684354560;
      t2_full = (pt_ff + 56'd134217728) >> FB;
      t3_full = (pt3_ff + 57'd134217728) >> FB;
      pf_in = $signed({1'b0, t3_ff}) * b_ff[2];
      fade_full = (pf_ff + 64'sd134217728) >>> FB;
   end

   always_ff @(posedge clock) begin
      t_ff[0] <= t_in;
      t_ff[1] <= t_ff[0];
      pa_ff <= pa_in;
      pt_ff <= pt_in;
      b_ff[0] <= b_in;
      b_ff[1] <= b_ff[0];
      b_ff[2] <= b_ff[1];
      t2_ff <= t2_full[28:0];
      pt3_ff <= 57'(t2_ff) * 57'(t_ff[1]);
      t3_ff <= t3_full[28:0];
      pf_ff <= pf_in;
      fade_ff <= fade_type'(fade_full);
   end

   assign fade_out = fade_ff;

endmodule

[rtl/pnz_corner.sv]
// corner hash, gradient and dot product, thirteen register stages
module pnz_corner (
   input  logic                clock,
   input  pnz_pkg::cell_type   cx_in,
   input  pnz_pkg::cell_type   cy_in,
   input  pnz_pkg::off_type    fx_in,
   input  pnz_pkg::off_type    fy_in,
   output pnz_pkg::corner_type dot_out
);
   import pnz_pkg::*;

   cell_type           cy_ff [2];
   off_type            fx_ff [7];
   off_type            fy_ff [7];
   norm_type           norm_ff [5];
   logic        [23:0] p1_ff [2];
   logic        [49:0] m1_ff;
   cell_type           s_ff;
   logic        [23:0] p2_ff [2];
   logic        [49:0] m2_ff;
   cell_type           h_ff;
   grad_type           gx_ff;
   grad_type           gy_ff;
   logic        [37:0] u_ff [3];
   logic        [50:0] ph_ff;
   logic        [50:0] pl_ff;
   logic        [31:0] q_ff;
   logic signed [31:0] dq_ff;
   logic signed [63:0] pn_ff;
   corner_type         n_ff;

   logic        [14:0] a1;
   logic        [23:0] p1_in;
   logic        [23:0] r1;
   logic        [23:0] h1;
   logic         [9:0] s_sum;
   cell_type           s_in;
   logic        [14:0] a2;
   logic        [23:0] p2_in;
   logic        [23:0] r2;
   logic        [23:0] h2;
   logic         [8:0] v;
   hmod_type           m_in;
   logic signed [37:0] d_in;
   logic signed [38:0] u_full;
   logic        [69:0] pr;
   logic        [37:0] r3;
   logic        [31:0] qc;
   logic signed [63:0] n_full;

   always_comb begin
      // first permute on the x corner
      a1 = 15'(cx_in) * 15'd34 + 15'd1;
      p1_in = 24'(a1) * 24'(cx_in);
      r1 = p1_ff[1] - 24'(m1_ff[49:34]) * 24'd289;
      h1 = (r1 >= 24'd289) ? r1 - 24'd289 : r1;
      s_sum = 10'(h1) + 10'(cy_ff[1]);
      s_in = (s_sum >= 10'd289) ? 9'(s_sum - 10'd289) : 9'(s_sum);
      // second permute
      a2 = 15'(s_ff) * 15'd34 + 15'd1;
      p2_in = 24'(a2) * 24'(s_ff);
      r2 = p2_ff[1] - 24'(m2_ff[49:34]) * 24'd289;
      h2 = (r2 >= 24'd289) ? r2 - 24'd289 : r2;
      // hash mod 41
      v = h_ff;
      if (v >= 9'd164) begin
         v = v - 9'd164;
      end
      if (v >= 9'd82) begin
         v = v - 9'd82;
      end
      if (v >= 9'd41) begin
         v = v - 9'd41;
      end
      m_in = v[5:0];
      // dot product, offset so the divide by 82 sees a positive value
      d_in = gx_ff * fx_ff[6] + gy_ff * fy_ff[6];
      u_full = d_in + 39'sd88046829609;
      pr = {ph_ff, 19'b0} + 70'(pl_ff);
      r3 = u_ff[2] - 38'(q_ff) * 38'd82;
      qc = (r3 >= 38'd82) ? q_ff + 32'd1 : q_ff;
      n_full = (pn_ff + 64'sd134217728) >>> FB;
   end

   always_ff @(posedge clock) begin
      cy_ff[0] <= cy_in;
      cy_ff[1] <= cy_ff[0];
      fx_ff[0] <= fx_in;
      fy_ff[0] <= fy_in;
      for (int i = 1; i < 7; i++) begin
         fx_ff[i] <= fx_ff[i-1];
         fy_ff[i] <= fy_ff[i-1];
      end
      p1_ff[0] <= p1_in;
      m1_ff <= p1_ff[0] * R289;
      p1_ff[1] <= p1_ff[0];
      s_ff <= s_in;
      p2_ff[0] <= p2_in;
      m2_ff <= p2_ff[0] * R289;
      p2_ff[1] <= p2_ff[0];
      h_ff <= h2[8:0];
      gx_ff <= grad_x(m_in);
      gy_ff <= grad_y(m_in);
      norm_ff[0] <= NORM_TBL[m_in];
      for (int i = 1; i < 5; i++) begin
         norm_ff[i] <= norm_ff[i-1];
      end
      u_ff[0] <= u_full[37:0];
      ph_ff <= u_ff[0][37:19] * R82;
      pl_ff <= u_ff[0][18:0] * R82;
      u_ff[1] <= u_ff[0];
      u_ff[2] <= u_ff[1];
      q_ff <= pr[69:38];
      dq_ff <= $signed(qc) - 32'sd1073741824;
      pn_ff <= dq_ff * $signed({1'b0, norm_ff[4]});
      n_ff <= corner_type'(n_full);
   end

   assign dot_out = n_ff;

endmodule

[rtl/perlin_noise_2d.sv]
// top level of the 2d gradient noise pipeline
//
//  channel   handshake          payload
//  request   start / busy       req_x_coord, req_y_coord
//  response  rsp_valid strobe   rsp_noise_value
//
//  one transaction enters per cycle; busy stays low
//  result strobes once its point has passed the coordinate split, corner, blend and scaling registers
//  reset clears the valid pipeline only
//  the receiver cannot stall, so nothing in the pipeline ever holds
module perlin_noise_2d #(
   parameter int IN_FRAC_BITS  = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_noise_value
);
   import pnz_pkg::*;

   localparam int IPW = 32 - IN_FRAC_BITS;
   localparam int UW = (IPW + 1 > 10) ? IPW + 1 : 10;
   localparam logic [UW:0] OFS = (UW + 1)'(289) << (IPW - 8);
   localparam int SH = 2 * FB - OUT_FRAC_BITS;
   localparam logic signed [63:0] RND_OUT = 64'sd1 <<< (SH - 1);
   localparam int DEPTH = 22;
   localparam int FADE_DLY = 7;

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   logic [UW-1:0]            ux_ff;
   logic [UW-1:0]            uy_ff;
   logic [UW+25:0]           prx_ff;
   logic [UW+25:0]           pry_ff;
   logic [IN_FRAC_BITS-1:0]  frx_ff;
   logic [IN_FRAC_BITS-1:0]  fry_ff;
   cell_type                 cx_ff;
   cell_type                 cy_ff;
   frac_type                 fx_ff;
   frac_type                 fy_ff;
   cell_type                 cx0_ff;
   cell_type                 cx1_ff;
   cell_type                 cy0_ff;
   cell_type                 cy1_ff;
   frac_type                 fx0_ff;
   frac_type                 fy0_ff;

   fade_type                 fdx_ff [FADE_DLY];
   fade_type                 fdy_ff [FADE_DLY];
   fade_type                 fdy_b_ff [2];
   logic signed [63:0]       p0_ff;
   logic signed [63:0]       p1_ff;
   corner_type               n00_ff;
   corner_type               n01_ff;
   corner_type               nx0_ff;
   corner_type               nx1_ff;
   logic signed [63:0]       p2_ff;
   corner_type               nx0_b_ff;
   corner_type               nxy_ff;
   logic signed [63:0]       ps_ff;
   logic signed [15:0]       noise_ff;

   logic signed [UW:0]       ux_full;
   logic signed [UW:0]       uy_full;
   logic [UW-1:0]            rx;
   logic [UW-1:0]            ry;
   logic [9:0]               rx10;
   logic [9:0]               ry10;
   off_type                  ofx0;
   off_type                  ofx1;
   off_type                  ofy0;
   off_type                  ofy1;
   corner_type               n00;
   corner_type               n10;
   corner_type               n01;
   corner_type               n11;
   fade_type                 fdx;
   fade_type                 fdy;
   logic signed [32:0]       d0;
   logic signed [32:0]       d1;
   logic signed [32:0]       d2;
   logic signed [63:0]       b0;
   logic signed [63:0]       b1;
   logic signed [63:0]       b2;
   logic signed [63:0]       r_full;
   logic signed [15:0]       noise_in;

   assign busy = 1'b0;

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], start};
      ux_full = $signed(req_x_coord[31:IN_FRAC_BITS]) + $signed(OFS);
      uy_full = $signed(req_y_coord[31:IN_FRAC_BITS]) + $signed(OFS);
      rx = ux_ff - UW'(prx_ff[UW+25:34]) * UW'(289);
      ry = uy_ff - UW'(pry_ff[UW+25:34]) * UW'(289);
      rx10 = rx[9:0];
      ry10 = ry[9:0];
      ofx0 = $signed({2'b0, fx0_ff});
      ofy0 = $signed({2'b0, fy0_ff});
      ofx1 = ofx0 - 30'sd268435456;
      ofy1 = ofy0 - 30'sd268435456;
      d0 = n10 - n00;
      d1 = n11 - n01;
      b0 = (p0_ff + 64'sd134217728) >>> FB;
      b1 = (p1_ff + 64'sd134217728) >>> FB;
      d2 = nx1_ff - nx0_ff;
      b2 = (p2_ff + 64'sd134217728) >>> FB;
      r_full = (ps_ff + RND_OUT) >>> SH;
      if (r_full > 64'sd32767) begin
         noise_in = 16'sd32767;
      end else if (r_full < -64'sd32768) begin
         noise_in = -16'sd32768;
      end else begin
         noise_in = r_full[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // coordinate split: floor cell mod 289 and fractional offset
   always_ff @(posedge clock) begin
      ux_ff <= ux_full[UW-1:0];
      uy_ff <= uy_full[UW-1:0];
      prx_ff <= ux_full[UW-1:0] * R289;
      pry_ff <= uy_full[UW-1:0] * R289;
      frx_ff <= req_x_coord[IN_FRAC_BITS-1:0];
      fry_ff <= req_y_coord[IN_FRAC_BITS-1:0];
      cx_ff <= (rx10 >= 10'd289) ? 9'(rx10 - 10'd289) : rx10[8:0];
      cy_ff <= (ry10 >= 10'd289) ? 9'(ry10 - 10'd289) : ry10[8:0];
      fx_ff <= {frx_ff, (FB - IN_FRAC_BITS)'(0)};
      fy_ff <= {fry_ff, (FB - IN_FRAC_BITS)'(0)};
      cx0_ff <= cx_ff;
      cy0_ff <= cy_ff;
      cx1_ff <= (cx_ff == 9'd288) ? 9'd0 : cx_ff + 9'd1;
      cy1_ff <= (cy_ff == 9'd288) ? 9'd0 : cy_ff + 9'd1;
      fx0_ff <= fx_ff;
      fy0_ff <= fy_ff;
   end

   pnz_corner u_c00 (.clock(clock), .cx_in(cx0_ff), .cy_in(cy0_ff),
                     .fx_in(ofx0), .fy_in(ofy0), .dot_out(n00));
   pnz_corner u_c10 (.clock(clock), .cx_in(cx1_ff), .cy_in(cy0_ff),
                     .fx_in(ofx1), .fy_in(ofy0), .dot_out(n10));
   pnz_corner u_c01 (.clock(clock), .cx_in(cx0_ff), .cy_in(cy1_ff),
                     .fx_in(ofx0), .fy_in(ofy1), .dot_out(n01));
   pnz_corner u_c11 (.clock(clock), .cx_in(cx1_ff), .cy_in(cy1_ff),
                     .fx_in(ofx1), .fy_in(ofy1), .dot_out(n11));

   pnz_fade u_fade_x (.clock(clock), .t_in(fx0_ff), .fade_out(fdx));
   pnz_fade u_fade_y (.clock(clock), .t_in(fy0_ff), .fade_out(fdy));

   // fade delay to line up with the corner results, then the blends and output scaling
   always_ff @(posedge clock) begin
      fdx_ff[0] <= fdx;
      fdy_ff[0] <= fdy;
      for (int i = 1; i < FADE_DLY; i++) begin
         fdx_ff[i] <= fdx_ff[i-1];
         fdy_ff[i] <= fdy_ff[i-1];
      end
      p0_ff <= d0 * fdx_ff[FADE_DLY-1];
      p1_ff <= d1 * fdx_ff[FADE_DLY-1];
      n00_ff <= n00;
      n01_ff <= n01;
      fdy_b_ff[0] <= fdy_ff[FADE_DLY-1];
      nx0_ff <= n00_ff + corner_type'(b0);
      nx1_ff <= n01_ff + corner_type'(b1);
      fdy_b_ff[1] <= fdy_b_ff[0];
      p2_ff <= d2 * fdy_b_ff[1];
      nx0_b_ff <= nx0_ff;
      nxy_ff <= nx0_b_ff + corner_type'(b2);
      ps_ff <= nxy_ff * $signed({1'b0, SCALE_K});
      noise_ff <= noise_in;
   end

   assign rsp_valid = valid_ff[DEPTH-1];
   assign rsp_noise_value = noise_ff;

endmodule

[tb/perlin_noise_2d_checker.sv]
// checker that predicts the 2d gradient noise output and compares each response
`timescale 1ns / 100ps
module perlin_noise_2d_checker #(
   parameter int IN_FRAC_BITS  = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_noise_value,
   output int                 fail_count,
   output int                 pending_count,
   output int                 sample_count
);
   import pnz_pkg::*;

   localparam longint ONE = longint'(1) << FB;

   logic signed [15:0] noise_queue [$];

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return floor_div(v + (longint'(1) << (s - 1)), longint'(1) << s);
   endfunction

   function automatic int unsigned hash_step(int unsigned v);
      return ((34 * v + 1) * v) % 289;
   endfunction

   function automatic longint gradient_dot(int unsigned cx, int unsigned cy,
                                           longint fx, longint fy);
      int unsigned h;
      longint m, t, tx, gxn, gyn, s, norm, dq;
      h = hash_step(hash_step(cx) + cy);
      m = h % 41;
      t = 2 * m - 41;
      tx = (m <= 10) ? -1 : ((m >= 31) ? 1 : 0);
      gxn = 2 * t - 82 * tx;
      gyn = 2 * (t < 0 ? -t : t) - 41;
      s = gxn * gxn + gyn * gyn;
      norm = longint'(NORM_C1) - floor_div(NORM_C2 * s + 3362, 6724);
      dq = floor_div(gxn * fx + gyn * fy + 41, 82);
      return round_shift(dq * norm, FB);
   endfunction

   function automatic longint quintic_fade(longint t);
      longint a, b, t2, t3;
      a = 6 * t - 15 * ONE;
      b = round_shift(a * t, FB) + 10 * ONE;
      t2 = round_shift(t * t, FB);
      t3 = round_shift(t2 * t, FB);
      return round_shift(t3 * b, FB);
   endfunction

   function automatic void split_point(logic signed [31:0] c, output int unsigned cell_idx,
                                       output longint offs);
      longint v, fr, r;
      v = longint'(c);
      fr = v & ((longint'(1) << IN_FRAC_BITS) - 1);
      r = ((v - fr) / (longint'(1) << IN_FRAC_BITS)) % 289;
      if (r < 0) r += 289;
      cell_idx = int'(r);
      offs = fr <<< (FB - IN_FRAC_BITS);
   endfunction

   function automatic logic signed [15:0] predict_noise(logic signed [31:0] xc,
                                                        logic signed [31:0] yc);
      int unsigned cx0, cy0, cx1, cy1;
      longint fx0, fy0, n00, n10, n01, n11, fdx, fdy, nx0, nx1, nxy, r;
      split_point(xc, cx0, fx0);
      split_point(yc, cy0, fy0);
      cx1 = (cx0 + 1) % 289;
      cy1 = (cy0 + 1) % 289;
      n00 = gradient_dot(cx0, cy0, fx0, fy0);
      n10 = gradient_dot(cx1, cy0, fx0 - ONE, fy0);
      n01 = gradient_dot(cx0, cy1, fx0, fy0 - ONE);
      n11 = gradient_dot(cx1, cy1, fx0 - ONE, fy0 - ONE);
      fdx = quintic_fade(fx0);
      fdy = quintic_fade(fy0);
      nx0 = n00 + round_shift((n10 - n00) * fdx, FB);
      nx1 = n01 + round_shift((n11 - n01) * fdx, FB);
      nxy = nx0 + round_shift((nx1 - nx0) * fdy, FB);
      r = round_shift(nxy * longint'(SCALE_K), 2 * FB - OUT_FRAC_BITS);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   initial begin
      fail_count = 0;
      sample_count = 0;
   end

   assign pending_count = noise_queue.size();

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            noise_queue.push_back(predict_noise(req_x_coord, req_y_coord));
         end
         if (rsp_valid) begin
            sample_count <= sample_count + 1;
            if (noise_queue.size() == 0) begin
               $display("%0t: unexpected transaction, actual %0d", $time, rsp_noise_value);
               fail_count <= fail_count + 1;
            end else if (noise_queue[0] !== rsp_noise_value) begin
               $display("%0t: noise mismatch, expected %0d, actual %0d", $time,
                        noise_queue[0], rsp_noise_value);
               fail_count <= fail_count + 1;
               void'(noise_queue.pop_front());
            end else begin
               void'(noise_queue.pop_front());
            end
         end
      end
   end
endmodule

[tb/tb_perlin_noise_2d.sv]
// testbench top: drives points into the noise pipeline and reports the verdict
`timescale 1ns / 100ps
module tb_perlin_noise_2d;
   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_x_coord;
   logic signed [31:0] req_y_coord;
   logic               rsp_valid;
   logic signed [15:0] rsp_noise_value;
   int                 fail_count;
   int                 pending_count;
   int                 sample_count;
   int                 cycle_count;
   int                 sent_count;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1950;

   perlin_noise_2d uut (.*);

   perlin_noise_2d_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .rsp_valid(rsp_valid), .rsp_noise_value(rsp_noise_value),
      .fail_count(fail_count), .pending_count(pending_count),
      .sample_count(sample_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // hold one point on the port until it is taken
   task automatic send_point(input logic signed [31:0] xc, input logic signed [31:0] yc);
      start <= 1'b1;
      req_x_coord <= xc;
      req_y_coord <= yc;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic maybe_idle(input bit allow);
      int n;
      if (allow && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 19);
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
         2: return $urandom_range(0, 1) ? 32'h7fff_0000 + 32'($urandom_range(0, 65535))
                                        : 32'h8000_0000 + 32'($urandom_range(0, 65535));
         3: return {16'($urandom_range(0, 300) - 10), 16'($urandom())};
         4: return {16'($urandom()), 16'($urandom_range(0, 1) ? 16'hffff : 16'h0000)};
         default: return $urandom();
      endcase
   endfunction

   logic [31:0] corner_vals [0:7] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
      32'hffff_ffff, 32'h0001_0000, 32'hffff_0000, 32'h0120_8000, 32'h0000_ffff};

   initial begin
      int drain;
      cycle_count = 0;
      sent_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < 8; i++) begin
         send_point(corner_vals[i], corner_vals[(i * 3 + 1) % 8]);
         send_point(corner_vals[(i + 5) % 8], corner_vals[i]);
      end
      for (int i = 0; i < 6; i++) send_point($urandom(), $urandom());
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         maybe_idle(i < RANDOM_ITEMS - 300);
         send_point(random_coord(), random_coord());
      end
      start <= 1'b0;
      drain = 0;
      while (pending_count != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (40) @(posedge clock);
      $display("sent %0d points incl. range extremes and cell wraps, checked %0d results",
               sent_count, sample_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
